@@ src/zbdt_pkg.sv @@
`timescale 1ns / 1ps

package zbdt_pkg;

  localparam int unsigned COORD_W = 12;
  localparam int unsigned DEPTH_W = 24;
  localparam int unsigned COLOR_W = 24;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned FRAME_W = 9;
  localparam int unsigned REG_IDX_W = 2;
  // internal dimension width, wide enough for the largest frame parameter
  localparam int unsigned DIM_W = 13;
  // linear pixel index width before trimming to the store address
  localparam int unsigned LIN_W = 24;

  localparam int unsigned DEF_MAX_WIDTH = 256;
  localparam int unsigned DEF_MAX_HEIGHT = 256;
  localparam int unsigned DEF_DEPTH_BITS = 24;

  localparam logic [FRAME_W-1:0] FRAME_RESET = FRAME_W'(256);

  localparam logic [MODE_W-1:0] MODE_PLOT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [DEPTH_W-1:0] depth_in;
    logic [COLOR_W-1:0] color_in;
  } frag_t;

  typedef struct packed {
    logic accepted;
    logic in_range;
    logic [COLOR_W-1:0] color_out;
    logic signed [DEPTH_W-1:0] depth_out;
  } res_t;

  typedef struct packed {
    logic [REG_IDX_W-1:0] reg_idx;
    logic [FRAME_W-1:0] wdata;
  } cfg_t;

endpackage

@@ src/zbdt_if.sv @@
`timescale 1ns / 1ps

interface zbdt_frag_if;
  import zbdt_pkg::*;
  logic valid;
  logic ready;
  frag_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface zbdt_res_if;
  import zbdt_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface zbdt_cfg_if;
  import zbdt_pkg::*;
  logic valid;
  logic ready;
  cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/zbdt_addr.sv @@
`timescale 1ns / 1ps

module zbdt_addr #(
  parameter int unsigned MAX_WIDTH = zbdt_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = zbdt_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned ADDR_W = 16
) (
  input  logic signed [zbdt_pkg::COORD_W-1:0] pos_x_i,
  input  logic signed [zbdt_pkg::COORD_W-1:0] pos_y_i,
  input  logic [zbdt_pkg::FRAME_W-1:0]        frame_width_i,
  input  logic [zbdt_pkg::FRAME_W-1:0]        frame_height_i,
  output logic                                inside_o,
  output logic [ADDR_W-1:0]                   addr_o
);
  import zbdt_pkg::*;

  logic [DIM_W-1:0] eff_w;
  logic [DIM_W-1:0] eff_h;
  logic             x_ok;
  logic             y_ok;
  logic [LIN_W-1:0] row_base;
  logic [LIN_W-1:0] lin;

  // frame registers above the store size act as the store size
  assign eff_w = (DIM_W'(frame_width_i) > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH)
                                                              : DIM_W'(frame_width_i);
  assign eff_h = (DIM_W'(frame_height_i) > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT)
                                                                : DIM_W'(frame_height_i);

  assign x_ok = !pos_x_i[COORD_W-1] && (DIM_W'(pos_x_i[COORD_W-2:0]) < eff_w);
  assign y_ok = !pos_y_i[COORD_W-1] && (DIM_W'(pos_y_i[COORD_W-2:0]) < eff_h);
  assign inside_o = x_ok && y_ok;

  // row stride is the effective width
  assign row_base = LIN_W'(pos_y_i[COORD_W-2:0]) * LIN_W'(eff_w);
  assign lin = row_base + LIN_W'(pos_x_i[COORD_W-2:0]);
  assign addr_o = lin[ADDR_W-1:0];

endmodule

@@ src/zbdt_mem.sv @@
`timescale 1ns / 1ps

module zbdt_mem #(
  parameter int unsigned ENTRIES = 65536,
  parameter int unsigned ADDR_W = 16,
  parameter int unsigned DATA_W = 48
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [ENTRIES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ src/z_buffer_depth_test.sv @@
`timescale 1ns / 1ps

// Framebuffer with a per-pixel depth test, holding depth and colour for
// MAX_WIDTH x MAX_HEIGHT pixels in one synchronous memory (one write and one
// read port, registered read). Fragments are handled one at a time: a plot
// (mode 0) or a pixel read (mode 2) passes from input transfer through the
// read state and the done state to its result, since the memory read is
// registered before the depth compare and the write back. A plot is written
// only when its depth is strictly greater (nearer) than the stored one;
// off-frame fragments are dropped. A clear (mode 1) sweeps the whole memory
// at one pixel per cycle. After reset the same sweep sets every pixel to
// black at the farthest depth; the input is not ready until the sweep ends,
// while the configuration port stays ready. The result sits in an output
// register, so a new fragment can be taken while the previous result still
// waits. Depth is stored in DEPTH_BITS signed bits; input depth is saturated
// to that range, read depth is saturated back to 24 bits. The user must write
// frame width and height only while the block is idle; the block itself does
// not enforce this.
module z_buffer_depth_test #(
  parameter int unsigned MAX_WIDTH = zbdt_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = zbdt_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned DEPTH_BITS = zbdt_pkg::DEF_DEPTH_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  zbdt_frag_if.sink     frag,
  zbdt_res_if.source    res,
  zbdt_cfg_if.sink      cfg
);
  import zbdt_pkg::*;

  localparam int unsigned ENTRIES = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned MEM_W = DEPTH_BITS + COLOR_W;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(ENTRIES - 1);

  // saturation bounds on a common 33-bit signed scale
  localparam logic signed [32:0] ZMIN = -(33'sd1 <<< (DEPTH_BITS - 1));
  localparam logic signed [32:0] ZMAX = (33'sd1 <<< (DEPTH_BITS - 1)) - 33'sd1;
  localparam logic signed [32:0] OMIN = -(33'sd1 <<< (DEPTH_W - 1));
  localparam logic signed [32:0] OMAX = (33'sd1 <<< (DEPTH_W - 1)) - 33'sd1;
  localparam logic [DEPTH_BITS-1:0] FAR_DEPTH = ZMIN[DEPTH_BITS-1:0];

  // sequencer states
  localparam logic [2:0] ST_INIT  = 3'd0;  // power-up sweep
  localparam logic [2:0] ST_IDLE  = 3'd1;  // waiting for a fragment
  localparam logic [2:0] ST_READ  = 3'd2;  // memory read in flight
  localparam logic [2:0] ST_CLEAR = 3'd3;  // clear sweep
  localparam logic [2:0] ST_DONE  = 3'd4;  // compare, write back, post result

  logic [2:0] state_q, state_d;
  logic [ADDR_W-1:0] clr_ptr_q, clr_ptr_d;
  logic [COLOR_W-1:0] clr_color_q, clr_color_d;
  logic [FRAME_W-1:0] frame_width_q, frame_height_q;

  // accepted fragment, held until its result is posted
  logic [MODE_W-1:0] mode_q;
  logic signed [COORD_W-1:0] pos_x_q, pos_y_q;
  logic [DEPTH_BITS-1:0] z_q;
  logic [COLOR_W-1:0] color_q;

  logic out_valid_q, out_valid_d;
  res_t out_data_q, out_data_d;

  logic frag_xfer;
  logic out_free;
  logic pix_in_frame;
  logic [ADDR_W-1:0] pix_addr;
  logic signed [32:0] z_wide;
  logic signed [32:0] z_sat;
  logic mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [MEM_W-1:0] mem_wdata;
  logic [MEM_W-1:0] mem_rdata;
  logic [DEPTH_BITS-1:0] rd_depth;
  logic [COLOR_W-1:0] rd_color;
  logic signed [32:0] rd_wide;
  logic signed [32:0] rd_sat;
  logic nearer;
  logic done_fire;

  assign frag.ready = (state_q == ST_IDLE);
  assign frag_xfer = frag.valid && frag.ready;
  assign cfg.ready = 1'b1;
  assign res.valid = out_valid_q;
  assign res.data = out_data_q;
  assign out_free = !out_valid_q || res.ready;

  // input depth saturated to the stored width
  assign z_wide = 33'(frag.data.depth_in);
  assign z_sat = (z_wide < ZMIN) ? ZMIN : ((z_wide > ZMAX) ? ZMAX : z_wide);

  // bounds check and pixel address from the held coordinates
  zbdt_addr #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .ADDR_W    (ADDR_W)
  ) u_addr (
    .pos_x_i       (pos_x_q),
    .pos_y_i       (pos_y_q),
    .frame_width_i (frame_width_q),
    .frame_height_i(frame_height_q),
    .inside_o      (pix_in_frame),
    .addr_o        (pix_addr)
  );

  // memory word: depth above colour
  zbdt_mem #(
    .ENTRIES(ENTRIES),
    .ADDR_W (ADDR_W),
    .DATA_W (MEM_W)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(pix_addr),
    .rdata_o(mem_rdata)
  );

  assign rd_depth = mem_rdata[MEM_W-1 -: DEPTH_BITS];
  assign rd_color = mem_rdata[COLOR_W-1:0];
  assign rd_wide = 33'($signed(rd_depth));
  assign rd_sat = (rd_wide < OMIN) ? OMIN : ((rd_wide > OMAX) ? OMAX : rd_wide);
  assign nearer = $signed(z_q) > $signed(rd_depth);

  // result posting waits for a free output register
  assign done_fire = (state_q == ST_DONE) && out_free;

  always_comb begin
    state_d = state_q;
    clr_ptr_d = clr_ptr_q;
    clr_color_d = clr_color_q;
    out_valid_d = out_valid_q && !res.ready;
    out_data_d = out_data_q;
    mem_we = 1'b0;
    mem_waddr = pix_addr;
    mem_wdata = {z_q, color_q};

    case (state_q)
      ST_INIT, ST_CLEAR: begin
        mem_we = 1'b1;
        mem_waddr = clr_ptr_q;
        mem_wdata = {FAR_DEPTH, clr_color_q};
        if (clr_ptr_q == LAST_ADDR) begin
          clr_ptr_d = '0;
          state_d = (state_q == ST_INIT) ? ST_IDLE : ST_DONE;
        end else begin
          clr_ptr_d = clr_ptr_q + ADDR_W'(1);
        end
      end
      ST_IDLE: begin
        if (frag_xfer) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        // read data for the pixel lands at the end of this cycle
        if (mode_q == MODE_CLEAR) begin
          clr_color_d = color_q;
          state_d = ST_CLEAR;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d = '0;
          case (mode_q)
            MODE_PLOT: begin
              out_data_d.in_range = pix_in_frame;
              if (pix_in_frame && nearer) begin
                mem_we = 1'b1;
                out_data_d.accepted = 1'b1;
              end
            end
            MODE_CLEAR: begin
              out_data_d.accepted = 1'b1;
            end
            MODE_READ: begin
              if (pix_in_frame) begin
                out_data_d.in_range = 1'b1;
                out_data_d.color_out = rd_color;
                out_data_d.depth_out = rd_sat[DEPTH_W-1:0];
              end
            end
            default: begin
              // unused mode: all-zero result, no store change
            end
          endcase
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      clr_ptr_q <= '0;
      clr_color_q <= '0;
      out_valid_q <= 1'b0;
      frame_width_q <= FRAME_RESET;
      frame_height_q <= FRAME_RESET;
    end else begin
      state_q <= state_d;
      clr_ptr_q <= clr_ptr_d;
      clr_color_q <= clr_color_d;
      out_valid_q <= out_valid_d;
      if (cfg.valid && cfg.ready) begin
        case (cfg.data.reg_idx)
          REG_FRAME_WIDTH: frame_width_q <= cfg.data.wdata;
          REG_FRAME_HEIGHT: frame_height_q <= cfg.data.wdata;
          default: begin
            // writes beyond the register list are ignored
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (frag_xfer) begin
      mode_q <= frag.data.mode;
      pos_x_q <= frag.data.pos_x;
      pos_y_q <= frag.data.pos_y;
      z_q <= z_sat[DEPTH_BITS-1:0];
      color_q <= frag.data.color_in;
    end
    if (done_fire) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

@@ src/zbdt_checker.sv @@
`timescale 1ns / 1ps

module zbdt_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            frag_valid_i,
  input logic            frag_ready_i,
  input logic            res_valid_i,
  input logic            res_ready_i,
  input zbdt_pkg::res_t  res_data_i
);
  import zbdt_pkg::*;

  // a waiting result holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_data_i))
    else $error("result changed while stalled");

  // one fragment in flight: no second transfer right after a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    frag_valid_i && frag_ready_i |=> !frag_ready_i)
    else $error("fragment taken while busy");

  // colour and depth come back only from an in-range read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_data_i.in_range |->
      res_data_i.color_out == '0 && res_data_i.depth_out == '0)
    else $error("pixel data on an out-of-range result");

  // accepted plots and clears never return pixel data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_data_i.accepted |->
      res_data_i.color_out == '0 && res_data_i.depth_out == '0)
    else $error("pixel data on a plot or clear result");

endmodule

bind z_buffer_depth_test zbdt_checker u_zbdt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .frag_valid_i(frag.valid),
  .frag_ready_i(frag.ready),
  .res_valid_i (res.valid),
  .res_ready_i (res.ready),
  .res_data_i  (res.data)
);
